@@ rtl/core/bac_pkg.sv @@
// ----------------------------------------------------------------------------
// bac_pkg
// Shared types and constants for the bit autocorrelation test block.
// ----------------------------------------------------------------------------
package bac_pkg;

  // Field widths
  localparam int DELAY_W = 13;
  localparam int COUNT_W = 32;
  localparam int DEV_W   = 33;
  localparam int BACK_W  = 11;  // history distance in bytes, from a 13-bit lag

  localparam logic [DELAY_W-1:0] DELAY_RESET = 13'd1;

  // Bit count stops here; a byte arriving above BIT_SAT_EDGE saturates
  localparam logic [COUNT_W-1:0] BIT_LIMIT    = 32'hFFFF_FFF8;
  localparam logic [COUNT_W-1:0] BIT_SAT_EDGE = BIT_LIMIT - 32'd8;
  localparam logic [4:0]         MIN_EXTRA    = 5'd10;

  // Exact form of |x| < 1.96: dev^2 * 2500 < 9604 * m
  localparam logic [11:0] PASS_LHS_SCALE = 12'd2500;
  localparam logic [13:0] PASS_RHS_SCALE = 14'd9604;
  localparam logic [17:0] DEV_PASS_GUARD = 18'd200000;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_SHORT     = 2'd1,
    STATUS_BAD_DELAY = 2'd2,
    STATUS_SATURATED = 2'd3
  } bac_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_FIN_STATUS,
    ST_FIN_SQUARE,
    ST_FIN_SCALE,
    ST_FIN_LOAD
  } bac_state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch input transaction, issue history reads
    logic update;   // compare bits, bump counters, write history
    logic report;   // status and deviation, clear stream state
    logic square;   // dev^2 and m * 9604
    logic scale;    // dev^2 * 2500
    logic load;     // fill output register
  } bac_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;      // captured transaction closes the stream
    logic out_free;  // output register can take a result this cycle
  } bac_stat_t;

endpackage

@@ rtl/core/bac_if.sv @@
// ----------------------------------------------------------------------------
// bac_if
// Valid/ready channels of the bit autocorrelation test block.
// ----------------------------------------------------------------------------
interface bac_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface bac_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [31:0]        bit_total;
  logic [31:0]        mismatch_total;
  logic signed [32:0] deviation;
  logic               passed;

  modport source (output valid, output status, output bit_total, output mismatch_total,
                  output deviation, output passed, input ready);
  modport sink   (input valid, input status, input bit_total, input mismatch_total,
                  input deviation, input passed, output ready);
endinterface

@@ rtl/core/bac_ctrl.sv @@
// ----------------------------------------------------------------------------
// bac_ctrl
// Sequencer: capture, update per byte; status, square, scale, load to close.
// ----------------------------------------------------------------------------
module bac_ctrl
  import bac_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  bac_stat_t stat,
  output bac_cmd_t  cmd
);

  bac_state_t state;
  bac_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = stat.last ? ST_FIN_STATUS : ST_IDLE;
      end
      ST_FIN_STATUS: state_next = ST_FIN_SQUARE;
      ST_FIN_SQUARE: state_next = ST_FIN_SCALE;
      ST_FIN_SCALE:  state_next = ST_FIN_LOAD;
      ST_FIN_LOAD: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_UPDATE:     cmd.update = 1'b1;
      ST_FIN_STATUS: cmd.report = 1'b1;
      ST_FIN_SQUARE: cmd.square = 1'b1;
      ST_FIN_SCALE:  cmd.scale  = 1'b1;
      ST_FIN_LOAD:   cmd.load   = stat.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/core/bac_datapath.sv @@
// ----------------------------------------------------------------------------
// bac_datapath
// Byte history, bit compare, counters, report arithmetic and output register.
// ----------------------------------------------------------------------------
module bac_datapath
  import bac_pkg::*;
#(
  parameter int MAX_DELAY     = 4096,
  parameter int HISTORY_BYTES = 1024
)(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [DELAY_W-1:0] cfg_data,
  input  logic [7:0]         data_byte,
  input  logic               last,
  input  bac_cmd_t           cmd,
  output bac_stat_t          stat,
  bac_out_if.source          out_ch
);

  localparam int AW = (HISTORY_BYTES > 2) ? $clog2(HISTORY_BYTES) : 1;
  localparam int SW = ((AW > BACK_W) ? AW : BACK_W) + 2;

  localparam logic signed [34:0] DEV_MAX = 35'sd4294967295;
  localparam logic signed [34:0] DEV_MIN = -35'sd4294967296;

  // Configuration and captured transaction
  logic [DELAY_W-1:0] delay;
  logic [7:0]         byte_reg;
  logic               last_reg;

  // Stream state
  logic [AW-1:0]      write_slot;
  logic [COUNT_W-1:0] bit_counter;
  logic [COUNT_W-1:0] mismatch_counter;
  logic               saturated;

  // History memory, two read ports, one write port
  logic [7:0] history [HISTORY_BYTES];
  logic [7:0] rd_new;
  logic [7:0] rd_old;

  // Report pipeline
  logic [COUNT_W-1:0] rep_n;
  logic [COUNT_W-1:0] rep_a;
  logic [DEV_W-1:0]   rep_dev;
  logic [1:0]         rep_status;
  logic [COUNT_W-1:0] rep_m;
  logic [17:0]        rep_mag;
  logic               rep_pass_ok;
  logic [35:0]        mag_sq;
  logic [45:0]        rhs;
  logic [47:0]        lhs;

  // Output register
  logic               out_valid;
  logic [1:0]         out_status;
  logic [COUNT_W-1:0] out_n;
  logic [COUNT_W-1:0] out_a;
  logic [DEV_W-1:0]   out_dev;
  logic               out_pass;

  // Comb signals
  logic [BACK_W-1:0] back_new;
  logic [BACK_W-1:0] back_old;
  logic [SW-1:0]     sum_new;
  logic [SW-1:0]     sum_old;
  logic [AW-1:0]     addr_new;
  logic [AW-1:0]     addr_old;
  logic              cmp_en;
  logic              sat_hit;
  logic              mem_we;
  logic [7:0]        new_src;
  logic [15:0]       window;
  logic [7:0]        aligned;
  logic [7:0]        pair_ok;
  logic [7:0]        diff;
  logic [3:0]        diff_cnt;
  logic [13:0]       pos_lo;
  logic              base_hi;
  logic [AW-1:0]     slot_inc;

  logic               short_data;
  logic               bad_delay;
  bac_status_t        status_c;
  logic signed [34:0] m_w;
  logic signed [34:0] dev_w;
  logic signed [34:0] dev_cl;
  logic [34:0]        mag_w;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      delay <= DELAY_RESET;
    end else if (cfg_write) begin
      delay <= cfg_data;
    end
  end

  // History read addresses: newer byte d/8 back, older one byte further
  always_comb begin
    back_new = BACK_W'(delay[DELAY_W-1:3]);
    back_old = back_new + 1'b1;
    sum_new  = SW'(write_slot) + SW'(HISTORY_BYTES) - SW'(back_new);
    sum_old  = SW'(write_slot) + SW'(HISTORY_BYTES) - SW'(back_old);
    if (sum_new >= SW'(HISTORY_BYTES)) sum_new = sum_new - SW'(HISTORY_BYTES);
    if (sum_old >= SW'(HISTORY_BYTES)) sum_old = sum_old - SW'(HISTORY_BYTES);
    addr_new = sum_new[AW-1:0];
    addr_old = sum_old[AW-1:0];
  end

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      byte_reg <= data_byte;
      last_reg <= last;
    end
  end

  // History memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      history[write_slot] <= byte_reg;
    end
    if (cmd.capture) begin
      rd_new <= history[addr_new];
      rd_old <= history[addr_old];
    end
  end

  // Eight bit compares against the lagged stream
  always_comb begin
    cmp_en   = (delay != '0) && ({19'b0, delay} <= 32'(MAX_DELAY));
    sat_hit  = bit_counter > BIT_SAT_EDGE;
    mem_we   = cmd.update && !saturated && !sat_hit;
    new_src  = (back_new == '0) ? byte_reg : rd_new;
    window   = {rd_old, new_src};
    aligned  = 8'(window >> delay[2:0]);
    base_hi  = |bit_counter[COUNT_W-1:DELAY_W];
    diff_cnt = '0;
    pos_lo   = '0;
    for (int k = 0; k < 8; k++) begin
      pos_lo        = {1'b0, bit_counter[DELAY_W-1:0]} + 14'(k);
      pair_ok[7-k]  = base_hi || (pos_lo >= {1'b0, delay});
    end
    diff = (byte_reg ^ aligned) & pair_ok;
    for (int k = 0; k < 8; k++) begin
      diff_cnt = diff_cnt + 4'(diff[k]);
    end
    slot_inc = (write_slot == AW'(HISTORY_BYTES - 1)) ? '0 : write_slot + 1'b1;
  end

  // Stream counters
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot       <= '0;
      bit_counter      <= '0;
      mismatch_counter <= '0;
      saturated        <= 1'b0;
    end else if (cmd.report) begin
      write_slot       <= '0;
      bit_counter      <= '0;
      mismatch_counter <= '0;
      saturated        <= 1'b0;
    end else if (cmd.update && !saturated) begin
      if (sat_hit) begin
        saturated <= 1'b1;
      end else begin
        write_slot  <= slot_inc;
        bit_counter <= bit_counter + 32'd8;
        if (cmp_en) mismatch_counter <= mismatch_counter + 32'(diff_cnt);
      end
    end
  end

  // Status and deviation
  always_comb begin
    short_data = {1'b0, bit_counter} < ({20'b0, delay} + 33'(MIN_EXTRA));
    bad_delay  = (delay == '0) || ({19'b0, delay} > (bit_counter >> 1))
                 || ({19'b0, delay} > 32'(MAX_DELAY));
    priority if (saturated) status_c = STATUS_SATURATED;
    else if (short_data)    status_c = STATUS_SHORT;
    else if (bad_delay)     status_c = STATUS_BAD_DELAY;
    else                    status_c = STATUS_OK;

    m_w   = $signed({3'b0, bit_counter}) - $signed({22'b0, delay});
    dev_w = $signed({2'b0, mismatch_counter, 1'b0}) - m_w;
    priority if (dev_w > DEV_MAX) dev_cl = DEV_MAX;
    else if (dev_w < DEV_MIN)     dev_cl = DEV_MIN;
    else                          dev_cl = dev_w;
    mag_w = dev_cl[34] ? 35'(-dev_cl) : 35'(dev_cl);
  end

  // Report pipeline: status, then products, then the scaled square for the compare
  always_ff @(posedge clk) begin
    if (cmd.report) begin
      rep_n       <= bit_counter;
      rep_a       <= mismatch_counter;
      rep_dev     <= dev_cl[DEV_W-1:0];
      rep_status  <= status_c;
      rep_m       <= m_w[COUNT_W-1:0];
      rep_mag     <= mag_w[17:0];
      rep_pass_ok <= (status_c == STATUS_OK) && !m_w[34] && (m_w != '0)
                     && (mag_w <= 35'(DEV_PASS_GUARD));
    end
    if (cmd.square) begin
      mag_sq <= 36'(rep_mag) * 36'(rep_mag);
      rhs    <= 46'(rep_m) * 46'(PASS_RHS_SCALE);
    end
    if (cmd.scale) begin
      lhs <= 48'(mag_sq) * 48'(PASS_LHS_SCALE);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status <= rep_status;
      out_n      <= rep_n;
      out_a      <= rep_a;
      out_dev    <= rep_dev;
      out_pass   <= rep_pass_ok && (lhs < {2'b0, rhs});
    end
  end

  assign stat.last     = last_reg;
  assign stat.out_free = !out_valid || out_ch.ready;

  assign out_ch.valid          = out_valid;
  assign out_ch.status         = out_status;
  assign out_ch.bit_total      = out_n;
  assign out_ch.mismatch_total = out_a;
  assign out_ch.deviation      = $signed(out_dev);
  assign out_ch.passed         = out_pass;

endmodule

@@ rtl/core/bit_autocorrelation_test.sv @@
// ----------------------------------------------------------------------------
// bit_autocorrelation_test
// Autocorrelation randomness test over a byte stream, bits MSB first.
//
//   channel   dir   payload                                           handshake
//   in_ch     in    data_byte[7:0], last                              valid/ready
//   out_ch    out   status[1:0], bit_total[31:0], mismatch_total[31:0],
//                   deviation[32:0] signed, passed                    valid/ready
//   cfg       in    cfg_data[12:0] (delay_bits)                       cfg_write
//
// Each byte is captured with a history read, then compared and counted; no new byte is taken until the update is done.
// A last byte then steps through status, products and scale, and the compare is made as the
// result enters the output register; the registered history read sets the pace.
// Results wait in the output register while the next stream is taken; a second
// last byte stalls until that register is free. Reset is synchronous, active high.
// The history memory needs no clearing: an entry not yet written is read only for masked-off bits.
// ----------------------------------------------------------------------------
module bit_autocorrelation_test
  import bac_pkg::*;
#(
  parameter int MAX_DELAY     = 4096,
  parameter int HISTORY_BYTES = 1024
)(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [DELAY_W-1:0] cfg_data,
  bac_in_if.sink             in_ch,
  bac_out_if.source          out_ch
);

  bac_cmd_t  cmd;
  bac_stat_t stat;
  logic      in_ready;

  bac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bac_datapath #(
    .MAX_DELAY     (MAX_DELAY),
    .HISTORY_BYTES (HISTORY_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .data_byte (in_ch.data_byte),
    .last      (in_ch.last),
    .cmd       (cmd),
    .stat      (stat),
    .out_ch    (out_ch)
  );

  assign in_ch.ready = in_ready;

`ifndef NO_ASSERTIONS
  // One transaction at a time: no accept in the cycle after an accept
  a_one_per_two: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted on consecutive cycles");

  // A pass requires a clean status
  a_pass_ok: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.passed) |-> (out_ch.status == STATUS_OK))
    else $error("pass reported with non-ok status");

  // Bit count never runs past its stop value
  a_bit_limit: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.bit_total <= BIT_LIMIT))
    else $error("bit count beyond limit");

  // Mismatches cannot outnumber the bits seen
  a_mismatch_bound: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.mismatch_total <= out_ch.bit_total))
    else $error("mismatch count exceeds bit count");
`endif

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bit autocorrelation test block. A queue of
// planned steps (stream bytes, lag register writes, drain points) feeds a
// clocked driver. Every accepted byte is run through a bit-level predictor
// that keeps its own history ring and counters, and each stream close queues
// one expected report. A clocked monitor checks every report field against
// the oldest expectation. Both channels stall randomly in two of three phases.
// ----------------------------------------------------------------------------
module tb;
  import bac_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 8;
  localparam int LAG_MAX        = 4096;
  localparam int HIST_DEPTH     = 1024;
  localparam int SETTLE_CYCLES  = 12;    // block latency with margin
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SHORT_BUDGET   = 540;   // bytes in ordinary random streams
  localparam int LONG_STREAM    = 1030;  // reaches status ok at the largest lag

  localparam logic [31:0] BIT_STOP_EDGE = 32'hFFFF_FFF0;
  localparam longint      SHORT_MARGIN  = 10;
  localparam longint      DEV_TOP       = 64'sd4294967295;
  localparam longint      DEV_BOTTOM    = -64'sd4294967296;
  localparam longint unsigned BOUND_GUARD = 200000;
  localparam longint unsigned BOUND_LHS   = 2500;
  localparam longint unsigned BOUND_RHS   = 9604;

  typedef enum logic [1:0] {STEP_BYTE, STEP_DRAIN, STEP_LAG} step_kind_t;

  typedef struct {
    step_kind_t        kind;
    logic [7:0]        data;
    logic              last;
    logic [DELAY_W-1:0] lag;
  } stream_step_t;

  typedef struct {
    bac_status_t        status;
    logic [31:0]        bit_total;
    logic [31:0]        mismatch_total;
    logic signed [32:0] deviation;
    logic               passed;
  } acf_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [DELAY_W-1:0] cfg_data  = '0;

  bac_in_if  in_ch();
  bac_out_if out_ch();

  bit_autocorrelation_test u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  // Planned steps and expected reports
  stream_step_t stream_plan[$];
  acf_result_t  acf_expected[$];

  // Predictor state
  logic [7:0]         hist_mem [HIST_DEPTH];
  int unsigned        hist_slot;
  logic [31:0]        bits_seen;
  logic [31:0]        diffs_seen;
  bit                 count_stuck;
  logic [DELAY_W-1:0] lag;

  // Bookkeeping
  int bytes_planned, bytes_taken, lag_writes, results_seen, errors;
  int bound_met, settle_count, quiet_cycles;
  int status_tally [4];
  int idle_phase;

  task automatic flag_error(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Fold one byte into the running counts; on the closing byte, return the
  // report in the queue and start a fresh stream
  function automatic void acf_predict(input logic [7:0] b, input logic last);
    logic [31:0] base, p, q, back;
    logic [7:0]  src;
    int unsigned idx;
    acf_result_t r;
    longint n, a, d, m, dev;
    longint unsigned mag;

    base = bits_seen;
    if (!count_stuck) begin
      if (base > BIT_STOP_EDGE) begin
        count_stuck = 1'b1;
      end else begin
        if (lag >= 1 && lag <= LAG_MAX) begin
          for (int k = 0; k < 8; k++) begin
            p = base + k;
            if (p >= 32'(lag)) begin
              q    = p - 32'(lag);
              back = (base >> 3) - (q >> 3);
              if (back == 0) begin
                src = b;
              end else begin
                idx = (hist_slot + HIST_DEPTH - (back % HIST_DEPTH)) % HIST_DEPTH;
                src = hist_mem[idx];
              end
              diffs_seen += 32'(b[7-k] ^ src[7 - q[2:0]]);
            end
          end
        end
        hist_mem[hist_slot] = b;
        hist_slot = (hist_slot + 1) % HIST_DEPTH;
        bits_seen = base + 32'd8;
      end
    end
    if (!last) return;

    n = bits_seen;
    a = diffs_seen;
    d = lag;
    if (count_stuck) r.status = STATUS_SATURATED;
    else if (n < d + SHORT_MARGIN) r.status = STATUS_SHORT;
    else if (d < 1 || d > n / 2 || d > LAG_MAX) r.status = STATUS_BAD_DELAY;
    else r.status = STATUS_OK;

    m   = n - d;
    dev = 2 * a - m;
    if (dev > DEV_TOP) dev = DEV_TOP;
    if (dev < DEV_BOTTOM) dev = DEV_BOTTOM;

    // exact integer form of |dev| / sqrt(m) < 1.96
    r.passed = 1'b0;
    if (r.status == STATUS_OK && m > 0) begin
      mag = (dev < 0) ? -dev : dev;
      if (mag <= BOUND_GUARD)
        r.passed = (mag * mag * BOUND_LHS) < (longint'(m) * BOUND_RHS);
    end
    r.bit_total      = n[31:0];
    r.mismatch_total = a[31:0];
    r.deviation      = dev[32:0];
    acf_expected.push_back(r);

    hist_slot   = 0;
    bits_seen   = '0;
    diffs_seen  = '0;
    count_stuck = 1'b0;
  endfunction

  // Driver: one input transaction, one lag write or one drain wait per step of the plan
  always @(posedge clk) begin
    logic next_valid, next_write;
    int   tx_idle;
    if (rst) begin
      in_ch.valid <= 1'b0;
      cfg_write   <= 1'b0;
    end else begin
      next_valid = in_ch.valid;
      next_write = 1'b0;
      case (idle_phase)
        0:       tx_idle = 31;
        1:       tx_idle = 67;
        default: tx_idle = 0;
      endcase
      if (in_ch.valid && in_ch.ready) begin
        acf_predict(in_ch.data_byte, in_ch.last);
        bytes_taken++;
        next_valid = 1'b0;
      end
      if (!next_valid && stream_plan.size() > 0) begin
        case (stream_plan[0].kind)
          STEP_BYTE: begin
            if ($urandom_range(99) >= tx_idle) begin
              in_ch.data_byte <= stream_plan[0].data;
              in_ch.last      <= stream_plan[0].last;
              next_valid = 1'b1;
              void'(stream_plan.pop_front());
            end
          end
          STEP_DRAIN: begin
            if (acf_expected.size() == 0) void'(stream_plan.pop_front());
          end
          STEP_LAG: begin
            // write only once the block has gone quiet
            if (acf_expected.size() != 0) begin
              settle_count = 0;
            end else if (settle_count < SETTLE_CYCLES) begin
              settle_count++;
            end else begin
              settle_count = 0;
              next_write = 1'b1;
              cfg_data <= stream_plan[0].lag;
              lag = stream_plan[0].lag;
              lag_writes++;
              void'(stream_plan.pop_front());
            end
          end
          default: ;
        endcase
      end
      in_ch.valid <= next_valid;
      cfg_write   <= next_write;
      idle_phase  <= (bytes_taken * 3 < bytes_planned) ? 0 :
                     (bytes_taken * 3 < bytes_planned * 2) ? 1 : 2;
    end
  end

  // Monitor: check each report transaction against the oldest prediction
  always @(posedge clk) begin
    acf_result_t want;
    int rx_idle;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      case (idle_phase)
        0:       rx_idle = 67;
        1:       rx_idle = 31;
        default: rx_idle = 0;
      endcase
      if (out_ch.valid && out_ch.ready) begin
        if (acf_expected.size() == 0) begin
          flag_error("report with no stream closed");
        end else begin
          want = acf_expected.pop_front();
          if (out_ch.status !== want.status)
            flag_error($sformatf("report %0d: status %0d, predicted %0d",
                                 results_seen, out_ch.status, want.status));
          if (out_ch.bit_total !== want.bit_total)
            flag_error($sformatf("report %0d: bit_total %0d, predicted %0d",
                                 results_seen, out_ch.bit_total, want.bit_total));
          if (out_ch.mismatch_total !== want.mismatch_total)
            flag_error($sformatf("report %0d: mismatch_total %0d, predicted %0d",
                                 results_seen, out_ch.mismatch_total,
                                 want.mismatch_total));
          if (out_ch.deviation !== want.deviation)
            flag_error($sformatf("report %0d: deviation %0d, predicted %0d",
                                 results_seen, out_ch.deviation, want.deviation));
          if (out_ch.passed !== want.passed)
            flag_error($sformatf("report %0d: passed %0b, predicted %0b",
                                 results_seen, out_ch.passed, want.passed));
          status_tally[want.status]++;
          if (want.passed) bound_met++;
        end
        results_seen++;
      end
      out_ch.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // Watchdog on cycles without any transaction or register write
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic plan_byte(input logic [7:0] data, input logic last);
    stream_plan.push_back('{STEP_BYTE, data, last, '0});
    bytes_planned++;
  endtask

  task automatic plan_lag(input int value);
    stream_plan.push_back('{STEP_LAG, 8'h00, 1'b0, DELAY_W'(value)});
  endtask

  // Stream content: random, constant, short repeating motif, or sparse ones
  task automatic plan_stream(input int len, input bit closed);
    logic [7:0] motif [4];
    logic [7:0] b;
    int style, period;
    style  = $urandom_range(99);
    period = $urandom_range(1, 4);
    foreach (motif[i]) motif[i] = 8'($urandom);
    for (int i = 0; i < len; i++) begin
      if (style < 50)      b = 8'($urandom);
      else if (style < 65) b = motif[0];
      else if (style < 85) b = motif[i % period];
      else                 b = 8'($urandom & $urandom);
      plan_byte(b, closed && (i == len - 1));
    end
  endtask

  initial begin
    int  sel, nstreams, len, full, pick, short_planned;
    bit  long_done, stream_open;

    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last      = 1'b0;
    out_ch.ready    = 1'b0;
    foreach (hist_mem[i]) hist_mem[i] = '0;
    hist_slot   = 0;
    bits_seen   = '0;
    diffs_seen  = '0;
    count_stuck = 1'b0;
    lag         = DELAY_W'(1);
    idle_phase  = 0;

    // Directed: lag 1 from reset, single-byte and tiny streams at the byte extremes
    plan_byte(8'h00, 1'b1);
    plan_byte(8'hFF, 1'b1);
    plan_byte(8'h55, 1'b0); plan_byte(8'hAA, 1'b1);
    plan_byte(8'hFF, 1'b0); plan_byte(8'h00, 1'b0); plan_byte(8'hFF, 1'b1);
    plan_byte(8'h00, 1'b0); plan_byte(8'h00, 1'b1);
    // zero lag: nothing compared, bad delay
    plan_lag(0);
    plan_byte(8'hA5, 1'b0); plan_byte(8'h3C, 1'b1);
    // whole-byte lag, status ok
    plan_lag(8);
    plan_byte(8'h12, 1'b0); plan_byte(8'h34, 1'b0); plan_byte(8'h12, 1'b1);
    // lag just over half the bits
    plan_lag(13);
    plan_byte(8'hF0, 1'b0); plan_byte(8'h0F, 1'b0); plan_byte(8'h99, 1'b1);
    // lag changed in the middle of a stream
    plan_lag(3);
    plan_byte(8'h81, 1'b0); plan_byte(8'h7E, 1'b0);
    plan_lag(5);
    plan_byte(8'hC3, 1'b1);
    // lags above the maximum
    plan_lag(8191);
    plan_byte(8'hFF, 1'b1);
    plan_lag(LAG_MAX + 1);
    plan_byte(8'h00, 1'b1);

    // Random phases: one lag per phase, a few streams each
    short_planned = 0;
    long_done     = 1'b0;
    stream_open   = 1'b0;
    while (short_planned < SHORT_BUDGET) begin
      if (!long_done && short_planned >= SHORT_BUDGET / 2) begin
        // largest lag over a stream long enough to wrap the history ring
        plan_lag(LAG_MAX);
        plan_stream(LONG_STREAM, 1'b1);
        long_done   = 1'b1;
        stream_open = 1'b0;
      end
      sel = $urandom_range(99);
      if (sel < 55)      pick = $urandom_range(1, 40);
      else if (sel < 80) pick = $urandom_range(41, 300);
      else if (sel < 90) pick = 0;
      else if (sel < 95) pick = $urandom_range(LAG_MAX + 1, 8191);
      else               pick = 8 * $urandom_range(1, 8);
      plan_lag(pick);
      nstreams = $urandom_range(1, 4);
      for (int s = 0; s < nstreams; s++) begin
        full = ((2 * pick > pick + 10 ? 2 * pick : pick + 10) + 7) / 8;
        sel  = $urandom_range(99);
        if (pick == 0 || pick > 300) len = $urandom_range(1, 8);
        else if (sel < 70)           len = full + $urandom_range(0, 10);
        else if (sel < 90)           len = $urandom_range(1, full);
        else                         len = $urandom_range(1, full + 20);
        // sometimes leave the last stream open across the next lag write
        stream_open = (s == nstreams - 1) && ($urandom_range(99) < 15);
        plan_stream(len, !stream_open);
        short_planned += len;
        if ($urandom_range(99) < 5) stream_plan.push_back('{STEP_DRAIN, 8'h00, 1'b0, '0});
      end
    end
    if (stream_open) plan_byte(8'($urandom), 1'b1);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (stream_plan.size() != 0 || in_ch.valid || acf_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d bytes over %0d lag writes (0 to 8191), %0d reports checked",
             bytes_taken, lag_writes, results_seen);
    $display("Status ok %0d, short %0d, bad lag %0d, saturated %0d; bound met %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3], bound_met);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ bit_autocorrelation_test.f @@
rtl/core/bac_pkg.sv
rtl/core/bac_if.sv
rtl/core/bac_ctrl.sv
rtl/core/bac_datapath.sv
rtl/core/bit_autocorrelation_test.sv
sim/tb.sv
